[hdl/afrr_pkg.sv]
// ============================================================================
// afrr_pkg: shared definitions of the addressed frame receiver and responder
// Sizes, codes, control word layout and the sequencer's microprogram.
// ============================================================================
package afrr_pkg;

    // Payload bytes of a frame; the frame also carries one command byte.
    localparam int PAYLOAD_BYTES = 4;
    localparam int FRAME_BYTES   = PAYLOAD_BYTES + 1;

    localparam int PTR_W     = $clog2(FRAME_BYTES);
    localparam int RIDX_W    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [4:0] PAYLOAD_LIM = 5'(PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_RECV,
        PH_SUM
    } rx_phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATION_ADDRESS,
        CFG_START_CODE,
        CFG_PING_COMMAND,
        CFG_DOUBLE_START
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SRC_START,
        SRC_ADDR,
        SRC_FRAME,
        SRC_REPLY,
        SRC_ACC
    } src_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_FRAME_END,
        LAST_YES
    } last_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_SEED,
        ACC_ADD_FRAME,
        ACC_ADD_REPLY
    } acc_op_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_CLR,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_FRAME_MORE,
        COND_REPLY_MORE,
        COND_SUM_BAD,
        COND_PING,
        COND_NOT_READY,
        COND_SINGLE
    } cond_t;

    typedef struct packed {
        logic              emit;
        logic              kind;
        src_t              src;
        last_t             last;
        acc_op_t           acc_op;
        ptr_op_t           ptr_op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              clr_frame;
        logic              clr_reply;
        logic              done;
    } ctrl_t;

    typedef struct packed {
        logic frame_more;
        logic reply_more;
        logic sum_bad;
        logic is_ping;
        logic reply_ready;
        logic double_start;
    } flags_t;

    // Program addresses.
    localparam logic [STEP_W-1:0] ST_INIT      = 4'd0;
    localparam logic [STEP_W-1:0] ST_SUM       = 4'd1;
    localparam logic [STEP_W-1:0] ST_CHECK     = 4'd2;
    localparam logic [STEP_W-1:0] ST_KIND      = 4'd3;
    localparam logic [STEP_W-1:0] ST_DELIVER   = 4'd4;
    localparam logic [STEP_W-1:0] ST_FINISH    = 4'd5;
    localparam logic [STEP_W-1:0] ST_PING      = 4'd6;
    localparam logic [STEP_W-1:0] ST_START1    = 4'd7;
    localparam logic [STEP_W-1:0] ST_START2    = 4'd8;
    localparam logic [STEP_W-1:0] ST_ADDR      = 4'd9;
    localparam logic [STEP_W-1:0] ST_PAYLOAD   = 4'd10;
    localparam logic [STEP_W-1:0] ST_CSUM      = 4'd11;
    localparam logic [STEP_W-1:0] ST_CLR_REPLY = 4'd12;

    // Microprogram run for each checksum byte.
    function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        case (step)
            ST_INIT:
            begin
                w.acc_op = ACC_SEED;
                w.ptr_op = PTR_CLR;
            end
            ST_SUM:
            begin
                w.acc_op = ACC_ADD_FRAME;
                w.ptr_op = PTR_INC;
                w.cond   = COND_FRAME_MORE;
                w.target = ST_SUM;
            end
            ST_CHECK:
            begin
                w.ptr_op = PTR_CLR;
                w.cond   = COND_SUM_BAD;
                w.target = ST_FINISH;
            end
            ST_KIND:
            begin
                w.cond   = COND_PING;
                w.target = ST_PING;
            end
            ST_DELIVER:
            begin
                w.emit   = 1'b1;
                w.kind   = 1'b0;
                w.src    = SRC_FRAME;
                w.last   = LAST_FRAME_END;
                w.ptr_op = PTR_INC;
                w.cond   = COND_FRAME_MORE;
                w.target = ST_DELIVER;
            end
            ST_FINISH:
            begin
                w.clr_frame = 1'b1;
                w.done      = 1'b1;
            end
            ST_PING:
            begin
                w.acc_op = ACC_SEED;
                w.ptr_op = PTR_CLR;
                w.cond   = COND_NOT_READY;
                w.target = ST_CLR_REPLY;
            end
            ST_START1:
            begin
                w.emit   = 1'b1;
                w.kind   = 1'b1;
                w.src    = SRC_START;
                w.cond   = COND_SINGLE;
                w.target = ST_ADDR;
            end
            ST_START2:
            begin
                w.emit = 1'b1;
                w.kind = 1'b1;
                w.src  = SRC_START;
            end
            ST_ADDR:
            begin
                w.emit = 1'b1;
                w.kind = 1'b1;
                w.src  = SRC_ADDR;
            end
            ST_PAYLOAD:
            begin
                w.emit   = 1'b1;
                w.kind   = 1'b1;
                w.src    = SRC_REPLY;
                w.acc_op = ACC_ADD_REPLY;
                w.ptr_op = PTR_INC;
                w.cond   = COND_REPLY_MORE;
                w.target = ST_PAYLOAD;
            end
            ST_CSUM:
            begin
                w.emit = 1'b1;
                w.kind = 1'b1;
                w.src  = SRC_ACC;
                w.last = LAST_YES;
            end
            ST_CLR_REPLY:
            begin
                w.clr_reply = 1'b1;
                w.cond      = COND_ALWAYS;
                w.target    = ST_FINISH;
            end
            default:
            begin
                w.clr_frame = 1'b1;
                w.done      = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

[hdl/afrr_if.sv]
// ============================================================================
// afrr_if: channel interfaces of the frame receiver
// Input item, result item and configuration write channels.
// ============================================================================
interface afrr_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic [3:0] reply_index;
    logic       arm_reply;

    modport source (output valid, action, data_byte, reply_index, arm_reply, input ready);
    modport sink (input valid, action, data_byte, reply_index, arm_reply, output ready);
endinterface

interface afrr_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, kind, out_byte, last, input ready);
    modport sink (input valid, kind, out_byte, last, output ready);
endinterface

interface afrr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [afrr_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/addressed_frame_receiver_responder_top.sv]
// ============================================================================
// addressed_frame_receiver_responder_top: bus slave frame receiver
// Frames received bytes, checks address and checksum, delivers frames and
// answers ping frames with an armed reply.
// ============================================================================
// A reply load or a non-checksum bus byte is absorbed without starting the
// sequencer, so the input stays ready. A checksum byte starts the microprogram:
// it sums the frame and ends on a bad checksum, else delivers the frame, or for
// a ping with an armed reply sends start code, address, reply payload and
// checksum, then clears the reply; each emitting step waits while the output register is full and not being taken.
// Reset clears configuration, receive phase, stores and the reply flag.
// ============================================================================
module addressed_frame_receiver_responder_top (
    input logic            clk,
    input logic            rst_n,
    afrr_cfg_if.sink       cfg,
    afrr_item_if.sink      item,
    afrr_result_if.source  result
);

    // Configuration registers. Writes are always taken; software only writes
    // them while no transaction is in flight, a rule the block does not enforce.
    logic [7:0] station_address_reg;
    logic [7:0] start_code_reg;
    logic [7:0] ping_command_reg;
    logic       double_start_reg;

    // Receive state and stores.
    afrr_pkg::rx_phase_t     phase_reg;
    afrr_pkg::rx_phase_t     phase_next;
    logic [afrr_pkg::CNT_W-1:0] rx_count_reg;
    logic [afrr_pkg::CNT_W-1:0] rx_count_next;
    logic [7:0] frame_reg [afrr_pkg::FRAME_BYTES];
    logic [7:0] frame_next [afrr_pkg::FRAME_BYTES];
    logic [7:0] reply_reg [afrr_pkg::PAYLOAD_BYTES];
    logic [7:0] reply_next [afrr_pkg::PAYLOAD_BYTES];
    logic       reply_ready_reg;
    logic       reply_ready_next;

    // Sequencer datapath: the checksum byte under test, an accumulator and
    // a pointer shared by frame and reply stores.
    logic [7:0]                 check_byte_reg;
    logic [7:0]                 check_byte_next;
    logic [7:0]                 acc_reg;
    logic [7:0]                 acc_next;
    logic [afrr_pkg::PTR_W-1:0] ptr_reg;
    logic [afrr_pkg::PTR_W-1:0] ptr_next;

    // Output register decouples the result channel from the sequencer.
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_kind_reg;
    logic       out_kind_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_last_reg;
    logic       out_last_next;

    afrr_pkg::ctrl_t  ctrl;
    afrr_pkg::flags_t flags;
    logic             seq_busy;
    logic             seq_fire;
    logic             seq_start;
    logic             stall;
    logic             emit_fire;
    logic             accept;
    logic             accept_bus;
    logic             accept_load;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic [7:0]       frame_sel;
    logic [7:0]       reply_sel;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_address_reg <= 8'h00;
            start_code_reg      <= 8'h00;
            ping_command_reg    <= 8'h00;
            double_start_reg    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                afrr_pkg::CFG_STATION_ADDRESS: station_address_reg <= cfg.data;
                afrr_pkg::CFG_START_CODE:      start_code_reg      <= cfg.data;
                afrr_pkg::CFG_PING_COMMAND:    ping_command_reg    <= cfg.data;
                afrr_pkg::CFG_DOUBLE_START:    double_start_reg    <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    // One item at a time: the input waits while a checksum byte is being
    // worked through.
    assign item.ready  = !seq_busy;
    assign accept      = item.valid && item.ready;
    assign accept_bus  = accept && !item.action;
    assign accept_load = accept && item.action;
    assign seq_start   = accept_bus && (phase_reg == afrr_pkg::PH_SUM);

    // Receive phase: next state.
    always_comb
    begin
        phase_next = phase_reg;
        if (seq_fire && ctrl.clr_frame)
        begin
            phase_next = afrr_pkg::PH_IDLE;
        end
        else if (accept_bus)
        begin
            case (phase_reg)
                afrr_pkg::PH_IDLE:
                begin
                    if (item.data_byte == start_code_reg)
                    begin
                        phase_next = afrr_pkg::PH_ADDR;
                    end
                end
                afrr_pkg::PH_ADDR:
                begin
                    phase_next = (item.data_byte == station_address_reg) ?
                                 afrr_pkg::PH_RECV : afrr_pkg::PH_IDLE;
                end
                afrr_pkg::PH_RECV:
                begin
                    if (rx_count_reg == afrr_pkg::CNT_W'(afrr_pkg::FRAME_BYTES - 1))
                    begin
                        phase_next = afrr_pkg::PH_SUM;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Receive phase: stores, counter and reply flag.
    always_comb
    begin
        rx_count_next    = rx_count_reg;
        frame_next       = frame_reg;
        reply_next       = reply_reg;
        reply_ready_next = reply_ready_reg;
        check_byte_next  = check_byte_reg;

        if (accept_bus)
        begin
            case (phase_reg)
                afrr_pkg::PH_IDLE:
                begin
                    if (item.data_byte == start_code_reg)
                    begin
                        rx_count_next = '0;
                    end
                end
                afrr_pkg::PH_RECV:
                begin
                    frame_next[rx_count_reg[afrr_pkg::PTR_W-1:0]] = item.data_byte;
                    rx_count_next = rx_count_reg + 1'b1;
                end
                afrr_pkg::PH_SUM:
                begin
                    check_byte_next = item.data_byte;
                end
                default:
                begin
                end
            endcase
        end

        // A reply index past the store is dropped; the arm bit still counts.
        if (accept_load)
        begin
            if ({1'b0, item.reply_index} < afrr_pkg::PAYLOAD_LIM)
            begin
                reply_next[item.reply_index[afrr_pkg::RIDX_W-1:0]] = item.data_byte;
            end
            if (item.arm_reply)
            begin
                reply_ready_next = 1'b1;
            end
        end

        if (seq_fire && ctrl.clr_frame)
        begin
            for (int i = 0; i < afrr_pkg::FRAME_BYTES; i++)
            begin
                frame_next[i] = 8'h00;
            end
        end

        if (seq_fire && ctrl.clr_reply)
        begin
            for (int i = 0; i < afrr_pkg::PAYLOAD_BYTES; i++)
            begin
                reply_next[i] = 8'h00;
            end
            reply_ready_next = 1'b0;
        end
    end

    // Datapath driven by the control word.
    assign frame_sel = frame_reg[ptr_reg];
    assign reply_sel = reply_reg[ptr_reg[afrr_pkg::RIDX_W-1:0]];

    assign flags.frame_more   = (ptr_reg != afrr_pkg::PTR_W'(afrr_pkg::FRAME_BYTES - 1));
    assign flags.reply_more   = (ptr_reg != afrr_pkg::PTR_W'(afrr_pkg::PAYLOAD_BYTES - 1));
    assign flags.sum_bad      = (acc_reg != check_byte_reg);
    assign flags.is_ping      = (frame_reg[0] == ping_command_reg);
    assign flags.reply_ready  = reply_ready_reg;
    assign flags.double_start = double_start_reg;

    // An emitting step holds while the output register is occupied and the result channel is not ready.
    assign stall     = ctrl.emit && out_valid_reg && !result.ready;
    assign emit_fire = seq_fire && ctrl.emit;

    always_comb
    begin
        case (ctrl.src)
            afrr_pkg::SRC_START: emit_byte = start_code_reg;
            afrr_pkg::SRC_ADDR:  emit_byte = station_address_reg;
            afrr_pkg::SRC_FRAME: emit_byte = frame_sel;
            afrr_pkg::SRC_REPLY: emit_byte = reply_sel;
            afrr_pkg::SRC_ACC:   emit_byte = acc_reg;
            default:             emit_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        case (ctrl.last)
            afrr_pkg::LAST_NO:        emit_last = 1'b0;
            afrr_pkg::LAST_FRAME_END: emit_last = !flags.frame_more;
            afrr_pkg::LAST_YES:       emit_last = 1'b1;
            default:                  emit_last = 1'b0;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        ptr_next = ptr_reg;
        if (seq_fire)
        begin
            case (ctrl.acc_op)
                afrr_pkg::ACC_HOLD:      acc_next = acc_reg;
                afrr_pkg::ACC_SEED:      acc_next = station_address_reg;
                afrr_pkg::ACC_ADD_FRAME: acc_next = acc_reg + frame_sel;
                afrr_pkg::ACC_ADD_REPLY: acc_next = acc_reg + reply_sel;
                default:                 acc_next = acc_reg;
            endcase
            case (ctrl.ptr_op)
                afrr_pkg::PTR_HOLD: ptr_next = ptr_reg;
                afrr_pkg::PTR_CLR:  ptr_next = '0;
                afrr_pkg::PTR_INC:  ptr_next = ptr_reg + 1'b1;
                default:            ptr_next = ptr_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = ctrl.kind;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.kind     = out_kind_reg;
    assign result.out_byte = out_byte_reg;
    assign result.last     = out_last_reg;

    afrr_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_start),
        .stall (stall),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (seq_busy),
        .fire  (seq_fire)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= afrr_pkg::PH_IDLE;
            rx_count_reg    <= '0;
            reply_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < afrr_pkg::FRAME_BYTES; i++)
            begin
                frame_reg[i] <= 8'h00;
            end
            for (int i = 0; i < afrr_pkg::PAYLOAD_BYTES; i++)
            begin
                reply_reg[i] <= 8'h00;
            end
        end
        else
        begin
            phase_reg       <= phase_next;
            rx_count_reg    <= rx_count_next;
            reply_ready_reg <= reply_ready_next;
            out_valid_reg   <= out_valid_next;
            frame_reg       <= frame_next;
            reply_reg       <= reply_next;
        end
    end

    always_ff @(posedge clk)
    begin
        check_byte_reg <= check_byte_next;
        acc_reg        <= acc_next;
        ptr_reg        <= ptr_next;
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
    end

    // A checksum byte always launches the microprogram.
    a_sum_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_bus && phase_reg == afrr_pkg::PH_SUM) |=> seq_busy)
        else $error("checksum byte did not start the sequencer");

    // Results only come out of a running program.
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> seq_busy)
        else $error("result emitted outside a program run");

    // Each program run leaves the receiver waiting for a new frame.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(seq_busy) |-> phase_reg == afrr_pkg::PH_IDLE)
        else $error("program ended without returning the receiver to idle");

    // The shared pointer stays inside the frame store on every step that
    // reads a frame byte.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_busy && (ctrl.acc_op == afrr_pkg::ACC_ADD_FRAME ||
                      ctrl.src == afrr_pkg::SRC_FRAME))
        |-> ptr_reg <= afrr_pkg::PTR_W'(afrr_pkg::FRAME_BYTES - 1))
        else $error("store pointer out of range");

endmodule

[hdl/afrr_sequencer.sv]
// ============================================================================
// afrr_sequencer: microprogram step counter
// Fetches one control word per step and resolves conditional jumps.
// ============================================================================
module afrr_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 stall,
    input  afrr_pkg::flags_t     flags,
    output afrr_pkg::ctrl_t      ctrl,
    output logic                 busy,
    output logic                 fire
);

    logic [afrr_pkg::STEP_W-1:0] step_reg;
    logic [afrr_pkg::STEP_W-1:0] step_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic                        take_jump;

    assign ctrl = afrr_pkg::ucode(step_reg);
    assign busy = busy_reg;
    assign fire = busy_reg && !stall;

    always_comb
    begin
        case (ctrl.cond)
            afrr_pkg::COND_NEVER:      take_jump = 1'b0;
            afrr_pkg::COND_ALWAYS:     take_jump = 1'b1;
            afrr_pkg::COND_FRAME_MORE: take_jump = flags.frame_more;
            afrr_pkg::COND_REPLY_MORE: take_jump = flags.reply_more;
            afrr_pkg::COND_SUM_BAD:    take_jump = flags.sum_bad;
            afrr_pkg::COND_PING:       take_jump = flags.is_ping;
            afrr_pkg::COND_NOT_READY:  take_jump = !flags.reply_ready;
            afrr_pkg::COND_SINGLE:     take_jump = !flags.double_start;
            default:                   take_jump = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                step_next = afrr_pkg::ST_INIT;
                busy_next = 1'b1;
            end
        end
        else if (fire)
        begin
            if (ctrl.done)
            begin
                busy_next = 1'b0;
            end
            else if (take_jump)
            begin
                step_next = ctrl.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= afrr_pkg::ST_INIT;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

endmodule
